### rtl/core/nfb_pkg.sv
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared constants and types for the nibble frame buffer drawer: store
// geometry, command codes, nibble masks and the control state encoding.
// ----------------------------------------------------------------------------
package nfb_pkg;

   localparam int DEF_SCREEN_WIDTH  = 128;
   localparam int DEF_SCREEN_HEIGHT = 128;

   localparam int STORE_DEPTH  = 8192;
   localparam int STORE_ADDR_W = 13;
   localparam int PIX_DATA_W   = 8;
   localparam int COORD_W      = 10;
   localparam int COUNT_W      = 15;

   localparam logic [COUNT_W-1:0]    COUNT_MAX   = 15'h7FFF;
   localparam logic [PIX_DATA_W-1:0] NIB_LO_MASK = 8'h0F;
   localparam logic [PIX_DATA_W-1:0] NIB_HI_MASK = 8'hF0;

   localparam logic [2:0] FUNC_CLEAR   = 3'd0;
   localparam logic [2:0] FUNC_LINE    = 3'd1;
   localparam logic [2:0] FUNC_OUTLINE = 3'd2;
   localparam logic [2:0] FUNC_FILL    = 3'd3;
   localparam logic [2:0] FUNC_READ    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LINE,
      ST_RECT,
      ST_READ,
      ST_FINISH
   } state_type;

endpackage

### rtl/core/nfb_ram.sv
// ----------------------------------------------------------------------------
// nfb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module nfb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/nibble_framebuffer_line_rect_drawer.sv
// ----------------------------------------------------------------------------
// nibble_framebuffer_line_rect_drawer
// Draws lines, rectangle outlines and filled rectangles into a 4-bit gray
// frame store packed two pixels per byte, clears it and reads bytes back.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   --------  -------------------  ---------------------------------------------
//   command   start / busy         req_func, req_x_start, req_y_start, req_x_end,
//                                  req_y_end, req_width, req_height, req_color,
//                                  req_read_address
//   result    rsp_valid (1 cycle)  rsp_read_data, rsp_pixels_written
//
// One pixel read-modify-write enters the store pipeline per cycle; the store's
// single write port sets the pace. A draw command walks all of its pixel
// positions (clipped ones included) and then gives its result; busy drops in
// the cycle after the result. Clear writes zero to each byte of the store once.
// After reset the block sweeps zeros through the store with busy high.
// Results cannot be stalled.
//
module nibble_framebuffer_line_rect_drawer #(
   parameter int SCREEN_WIDTH  = nfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = nfb_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_func,
   input  logic [7:0]                        req_x_start,
   input  logic [7:0]                        req_y_start,
   input  logic [7:0]                        req_x_end,
   input  logic [7:0]                        req_y_end,
   input  logic [7:0]                        req_width,
   input  logic [7:0]                        req_height,
   input  logic [3:0]                        req_color,
   input  logic [nfb_pkg::STORE_ADDR_W-1:0]  req_read_address,
   output logic                              rsp_valid,
   output logic [nfb_pkg::PIX_DATA_W-1:0]    rsp_read_data,
   output logic [nfb_pkg::COUNT_W-1:0]       rsp_pixels_written
);

   import nfb_pkg::*;

   localparam logic [STORE_ADDR_W-1:0] SWEEP_LAST = STORE_ADDR_W'(STORE_DEPTH - 1);

   state_type state_ff, state_in;

   // command fields
   logic [2:0]              cmd_func_ff;
   logic [7:0]              cmd_xs_ff, cmd_ys_ff, cmd_xe_ff, cmd_ye_ff;
   logic [7:0]              cmd_w_ff, cmd_h_ff;
   logic [3:0]              cmd_color_ff;
   logic [STORE_ADDR_W-1:0] cmd_addr_ff;

   // line walker
   logic [7:0]        lx_ff, lx_in, ly_ff, ly_in;
   logic [7:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic              sx_ff, sx_in, sy_ff, sy_in;
   logic signed [10:0] err_ff, err_in;
   logic signed [11:0] line_e, line_ndy, line_pdx;
   logic              line_c1, line_c2, line_done;

   // rectangle runs
   logic [COORD_W-1:0] run_x_ff, run_x_in, run_y_ff, run_y_in;
   logic [7:0]         run_left_ff, run_left_in;
   logic               run_vert_ff, run_vert_in;
   logic [1:0]         seg_ff, seg_in;
   logic [7:0]         rows_ff, rows_in;
   logic               rect_done;

   // clearing sweep
   logic [STORE_ADDR_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic                    sweep_rsp_ff, sweep_rsp_in;

   logic [COUNT_W-1:0] count_ff, count_in;

   // pixel issue
   logic                    accept;
   logic                    gen_valid;
   logic [COORD_W-1:0]      gen_x, gen_y;
   logic                    pix_valid;
   logic [16:0]             pix_sum;
   logic [STORE_ADDR_W-1:0] pix_addr;

   // store access and write-back stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [STORE_ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic                    s1_odd_ff, s1_odd_in;
   logic                    wr_last_valid_ff;
   logic [STORE_ADDR_W-1:0] wr_last_addr_ff;
   logic [PIX_DATA_W-1:0]   wr_last_data_ff;
   logic [PIX_DATA_W-1:0]   old_data, new_data;

   logic                    ram_we;
   logic [STORE_ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [PIX_DATA_W-1:0]   ram_wdata, ram_rdata;

   assign accept = start && !busy;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_CLEAR:   state_in = ST_SWEEP;
                  FUNC_LINE:    state_in = ST_LINE;
                  FUNC_OUTLINE,
                  FUNC_FILL:    state_in = (req_width == 8'd0 || req_height == 8'd0)
                                           ? ST_FINISH : ST_RECT;
                  FUNC_READ:    state_in = ST_READ;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_cnt_ff == SWEEP_LAST) begin
               state_in = sweep_rsp_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_LINE: begin
            if (line_done) state_in = ST_FINISH;
         end
         ST_RECT: begin
            if (rect_done) state_in = ST_FINISH;
         end
         ST_READ:   state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      gen_valid = 1'b0;
      gen_x     = run_x_ff;
      gen_y     = run_y_ff;
      ram_raddr = pix_addr;
      case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_LINE: begin
            gen_valid = 1'b1;
            gen_x     = {2'b00, lx_ff};
            gen_y     = {2'b00, ly_ff};
         end
         ST_RECT:   gen_valid = 1'b1;
         ST_READ:   ram_raddr = cmd_addr_ff;
         ST_FINISH: rsp_valid = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   assign rsp_read_data      = (cmd_func_ff == FUNC_READ) ? old_data : '0;
   assign rsp_pixels_written = count_ff;

   // ---------------------------------------------------------------- pixel address
   assign pix_valid = gen_valid
                   && (gen_x < COORD_W'(SCREEN_WIDTH))
                   && (gen_y < COORD_W'(SCREEN_HEIGHT));
   // on-screen coordinates fit in 8 bits; byte index wraps at the store depth
   assign pix_sum  = 17'({9'd0, gen_y[7:0]} * 17'(SCREEN_WIDTH)) + 17'(gen_x[7:0]);
   assign pix_addr = pix_sum[STORE_ADDR_W:1];

   // ---------------------------------------------------------------- line step
   assign line_done = (lx_ff == cmd_xe_ff) && (ly_ff == cmd_ye_ff);
   assign line_e    = {err_ff, 1'b0};
   assign line_ndy  = -$signed({4'd0, dy_ff});
   assign line_pdx  = $signed({4'd0, dx_ff});
   assign line_c1   = line_e > line_ndy;
   assign line_c2   = line_e < line_pdx;

   assign rect_done = (run_left_ff == 8'd1)
                   && ((cmd_func_ff == FUNC_FILL) ? (rows_ff == 8'd1) : (seg_ff == 2'd3));

   always_comb begin
      lx_in       = lx_ff;
      ly_in       = ly_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      err_in      = err_ff;
      run_x_in    = run_x_ff;
      run_y_in    = run_y_ff;
      run_left_in = run_left_ff;
      run_vert_in = run_vert_ff;
      seg_in      = seg_ff;
      rows_in     = rows_ff;
      count_in    = count_ff;

      if (accept) begin
         lx_in       = req_x_start;
         ly_in       = req_y_start;
         dx_in       = (req_x_end > req_x_start) ? req_x_end - req_x_start
                                                 : req_x_start - req_x_end;
         dy_in       = (req_y_end > req_y_start) ? req_y_end - req_y_start
                                                 : req_y_start - req_y_end;
         sx_in       = req_x_start < req_x_end;
         sy_in       = req_y_start < req_y_end;
         err_in      = $signed({3'd0, dx_in}) - $signed({3'd0, dy_in});
         run_x_in    = {2'b00, req_x_start};
         run_y_in    = {2'b00, req_y_start};
         run_left_in = req_width;
         run_vert_in = 1'b0;
         seg_in      = 2'd0;
         rows_in     = req_height;
         count_in    = '0;
      end else begin
         if (pix_valid && count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (state_ff == ST_LINE && !line_done) begin
            err_in = err_ff - (line_c1 ? $signed({3'd0, dy_ff}) : 11'sd0)
                            + (line_c2 ? $signed({3'd0, dx_ff}) : 11'sd0);
            if (line_c1) lx_in = sx_ff ? lx_ff + 8'd1 : lx_ff - 8'd1;
            if (line_c2) ly_in = sy_ff ? ly_ff + 8'd1 : ly_ff - 8'd1;
         end
         if (state_ff == ST_RECT && !rect_done) begin
            if (run_left_ff != 8'd1) begin
               run_left_in = run_left_ff - 8'd1;
               if (run_vert_ff) run_y_in = run_y_ff + COORD_W'(1);
               else             run_x_in = run_x_ff + COORD_W'(1);
            end else if (cmd_func_ff == FUNC_FILL) begin
               // next row of the fill
               run_x_in    = {2'b00, cmd_xs_ff};
               run_y_in    = run_y_ff + COORD_W'(1);
               run_left_in = cmd_w_ff;
               rows_in     = rows_ff - 8'd1;
            end else begin
               seg_in = seg_ff + 2'd1;
               case (seg_ff)
                  2'd0: begin
                     run_x_in    = {2'b00, cmd_xs_ff};
                     run_y_in    = {2'b00, cmd_ys_ff} + {2'b00, cmd_h_ff} - COORD_W'(1);
                     run_left_in = cmd_w_ff;
                     run_vert_in = 1'b0;
                  end
                  2'd1: begin
                     run_x_in    = {2'b00, cmd_xs_ff};
                     run_y_in    = {2'b00, cmd_ys_ff};
                     run_left_in = cmd_h_ff;
                     run_vert_in = 1'b1;
                  end
                  default: begin
                     run_x_in    = {2'b00, cmd_xs_ff} + {2'b00, cmd_w_ff} - COORD_W'(1);
                     run_y_in    = {2'b00, cmd_ys_ff};
                     run_left_in = cmd_h_ff;
                     run_vert_in = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------- sweep
   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      sweep_rsp_in = sweep_rsp_ff;
      if (accept && req_func == FUNC_CLEAR) begin
         sweep_cnt_in = '0;
         sweep_rsp_in = 1'b1;
      end else if (state_ff == ST_SWEEP) begin
         sweep_cnt_in = sweep_cnt_ff + STORE_ADDR_W'(1);
      end
   end

   // ---------------------------------------------------------------- store access
   assign s1_valid_in = pix_valid;
   assign s1_addr_in  = ram_raddr;
   assign s1_odd_in   = gen_x[0];

   // forward the write of the previous cycle: the RAM read may have missed it
   assign old_data = (wr_last_valid_ff && wr_last_addr_ff == s1_addr_ff)
                   ? wr_last_data_ff : ram_rdata;
   assign new_data = s1_odd_ff ? ((old_data & NIB_HI_MASK) | {4'd0, cmd_color_ff})
                               : ((old_data & NIB_LO_MASK) | {cmd_color_ff, 4'd0});

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = s1_valid_ff;
         ram_waddr = s1_addr_ff;
         ram_wdata = new_data;
      end
   end

   nfb_ram #(
      .DATA_W (PIX_DATA_W),
      .DEPTH  (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_SWEEP;
         sweep_cnt_ff     <= '0;
         sweep_rsp_ff     <= 1'b0;
         s1_valid_ff      <= 1'b0;
         wr_last_valid_ff <= 1'b0;
         cmd_func_ff      <= FUNC_CLEAR;
         count_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         sweep_cnt_ff     <= sweep_cnt_in;
         sweep_rsp_ff     <= sweep_rsp_in;
         s1_valid_ff      <= s1_valid_in;
         wr_last_valid_ff <= ram_we;
         if (accept) cmd_func_ff <= req_func;
         count_ff         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_xs_ff    <= req_x_start;
         cmd_ys_ff    <= req_y_start;
         cmd_xe_ff    <= req_x_end;
         cmd_ye_ff    <= req_y_end;
         cmd_w_ff     <= req_width;
         cmd_h_ff     <= req_height;
         cmd_color_ff <= req_color;
         cmd_addr_ff  <= req_read_address;
      end
      lx_ff           <= lx_in;
      ly_ff           <= ly_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      err_ff          <= err_in;
      run_x_ff        <= run_x_in;
      run_y_ff        <= run_y_in;
      run_left_ff     <= run_left_in;
      run_vert_ff     <= run_vert_in;
      seg_ff          <= seg_in;
      rows_ff         <= rows_in;
      s1_addr_ff      <= s1_addr_in;
      s1_odd_ff       <= s1_odd_in;
      wr_last_addr_ff <= ram_waddr;
      wr_last_data_ff <= ram_wdata;
   end

endmodule

### bench/tb_nibble_framebuffer_line_rect_drawer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nibble_framebuffer_line_rect_drawer
// Drives clear, line, outline, fill, read and unused commands into the drawer.
// A shadow frame store predicts read-back bytes and on-screen pixel counts.
// A directed table comes first, then random commands with random idle gaps.
// ----------------------------------------------------------------------------
module tb_nibble_framebuffer_line_rect_drawer;

   import nfb_pkg::*;

   localparam int SCREEN_W    = DEF_SCREEN_WIDTH;
   localparam int SCREEN_H    = DEF_SCREEN_HEIGHT;
   localparam int RANDOM_CMDS = 725;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 64;

   localparam logic [2:0] FUNC_SPARE_A = 3'd5;
   localparam logic [2:0] FUNC_SPARE_B = 3'd6;
   localparam logic [2:0] FUNC_SPARE_C = 3'd7;

   typedef struct {
      logic [2:0]              func;
      logic [7:0]              xs;
      logic [7:0]              ys;
      logic [7:0]              xe;
      logic [7:0]              ye;
      logic [7:0]              w;
      logic [7:0]              h;
      logic [3:0]              color;
      logic [STORE_ADDR_W-1:0] addr;
   } draw_cmd_type;

   typedef struct {
      logic [PIX_DATA_W-1:0] read_data;
      logic [COUNT_W-1:0]    pixels;
   } draw_report_type;

   typedef struct {
      draw_cmd_type    cmd;
      bit              typed;
      draw_report_type report;
   } table_row_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_func = '0;
   logic [7:0]              req_x_start = '0;
   logic [7:0]              req_y_start = '0;
   logic [7:0]              req_x_end = '0;
   logic [7:0]              req_y_end = '0;
   logic [7:0]              req_width = '0;
   logic [7:0]              req_height = '0;
   logic [3:0]              req_color = '0;
   logic [STORE_ADDR_W-1:0] req_read_address = '0;
   logic                    rsp_valid;
   logic [PIX_DATA_W-1:0]   rsp_read_data;
   logic [COUNT_W-1:0]      rsp_pixels_written;

   logic [PIX_DATA_W-1:0] shadow_store [STORE_DEPTH];
   int                    plot_total;
   draw_report_type       pending_reports [$];
   table_row_type         directed_rows [$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    func_tally [8];

   nibble_framebuffer_line_rect_drawer dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_x_start        (req_x_start),
      .req_y_start        (req_y_start),
      .req_x_end          (req_x_end),
      .req_y_end          (req_y_end),
      .req_width          (req_width),
      .req_height         (req_height),
      .req_color          (req_color),
      .req_read_address   (req_read_address),
      .rsp_valid          (rsp_valid),
      .rsp_read_data      (rsp_read_data),
      .rsp_pixels_written (rsp_pixels_written)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- shadow
   function automatic void put_pixel(int x, int y, logic [3:0] c);
      int idx;
      if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H) return;
      idx = ((y * SCREEN_W + x) / 2) % STORE_DEPTH;
      if (x % 2 == 0)
         shadow_store[idx] = (shadow_store[idx] & NIB_LO_MASK) | {c, 4'h0};
      else
         shadow_store[idx] = (shadow_store[idx] & NIB_HI_MASK) | {4'h0, c};
      if (plot_total < int'(COUNT_MAX)) plot_total++;
   endfunction

   function automatic void trace_line(int x0, int y0, int x1, int y1, logic [3:0] c);
      int dx, dy, sx, sy, err, e;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx  = (x0 < x1) ? 1 : -1;
      sy  = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      while (1) begin
         put_pixel(x0, y0, c);
         if (x0 == x1 && y0 == y1) break;
         e = err * 2;
         if (e > -dy) begin
            err -= dy;
            x0  += sx;
         end
         if (e < dx) begin
            err += dx;
            y0  += sy;
         end
      end
   endfunction

   // Apply one command to the shadow store and return the result it yields.
   function automatic draw_report_type render_command(draw_cmd_type c);
      draw_report_type r;
      int xs, ys, w, h;
      xs = int'(c.xs);
      ys = int'(c.ys);
      w  = int'(c.w);
      h  = int'(c.h);
      r.read_data = '0;
      plot_total  = 0;
      case (c.func)
         FUNC_CLEAR: begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
         end
         FUNC_LINE: begin
            trace_line(int'(c.xs), int'(c.ys), int'(c.xe), int'(c.ye), c.color);
         end
         FUNC_OUTLINE: begin
            if (w != 0 && h != 0) begin
               for (int i = 0; i < w; i++) put_pixel(xs + i, ys, c.color);
               for (int i = 0; i < w; i++) put_pixel(xs + i, ys + h - 1, c.color);
               for (int i = 0; i < h; i++) put_pixel(xs, ys + i, c.color);
               for (int i = 0; i < h; i++) put_pixel(xs + w - 1, ys + i, c.color);
            end
         end
         FUNC_FILL: begin
            for (int j = 0; j < h; j++)
               for (int i = 0; i < w; i++) put_pixel(xs + i, ys + j, c.color);
         end
         FUNC_READ: begin
            r.read_data = shadow_store[c.addr];
         end
         default: ;
      endcase
      r.pixels = plot_total[COUNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic draw_cmd_type mk_cmd(logic [2:0] func, int xs, int ys, int xe, int ye,
                                           int w, int h, int color, int addr);
      draw_cmd_type c;
      c.func  = func;
      c.xs    = xs[7:0];
      c.ys    = ys[7:0];
      c.xe    = xe[7:0];
      c.ye    = ye[7:0];
      c.w     = w[7:0];
      c.h     = h[7:0];
      c.color = color[3:0];
      c.addr  = addr[STORE_ADDR_W-1:0];
      return c;
   endfunction

   task automatic add_row(draw_cmd_type c, bit typed, int rd, int px);
      table_row_type row;
      row.cmd              = c;
      row.typed            = typed;
      row.report.read_data = rd[PIX_DATA_W-1:0];
      row.report.pixels    = px[COUNT_W-1:0];
      directed_rows.push_back(row);
   endtask

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int pick;
      c.func  = 3'($urandom);
      c.xs    = 8'($urandom);
      c.ys    = 8'($urandom);
      c.xe    = 8'($urandom);
      c.ye    = 8'($urandom);
      c.w     = 8'($urandom);
      c.h     = 8'($urandom);
      c.color = 4'($urandom);
      c.addr  = STORE_ADDR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         c.func = FUNC_CLEAR;
      end else if (pick < 32) begin
         c.func = FUNC_LINE;
         if ($urandom_range(0, 4) != 0) begin
            c.xs = 8'($urandom_range(0, SCREEN_W - 1));
            c.ys = 8'($urandom_range(0, SCREEN_H - 1));
            c.xe = 8'($urandom_range(0, SCREEN_W - 1));
            c.ye = 8'($urandom_range(0, SCREEN_H - 1));
         end
         if ($urandom_range(0, 9) == 0) begin
            c.xe = c.xs;
            c.ye = c.ys;
         end
      end else if (pick < 52) begin
         c.func = FUNC_OUTLINE;
         if ($urandom_range(0, 4) != 0) begin
            c.xs = 8'($urandom_range(0, SCREEN_W - 1));
            c.ys = 8'($urandom_range(0, SCREEN_H - 1));
         end
         if ($urandom_range(0, 99) < 85) begin
            c.w = 8'($urandom_range(0, 20));
            c.h = 8'($urandom_range(0, 20));
         end
      end else if (pick < 72) begin
         c.func = FUNC_FILL;
         if ($urandom_range(0, 4) != 0) begin
            c.xs = 8'($urandom_range(0, SCREEN_W - 1));
            c.ys = 8'($urandom_range(0, SCREEN_H - 1));
         end
         // keep most fills small, a large one now and then
         if ($urandom_range(0, 99) < 95) begin
            c.w = 8'($urandom_range(0, 16));
            c.h = 8'($urandom_range(0, 16));
         end
      end else if (pick < 95) begin
         c.func = FUNC_READ;
      end else begin
         c.func = 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
      end
      return c;
   endfunction

   // Transfer one command, then book its predicted result.
   task automatic drive_cmd(draw_cmd_type c, int gap, bit typed, draw_report_type typed_rpt);
      draw_report_type r;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func         <= c.func;
      req_x_start      <= c.xs;
      req_y_start      <= c.ys;
      req_x_end        <= c.xe;
      req_y_end        <= c.ye;
      req_width        <= c.w;
      req_height       <= c.h;
      req_color        <= c.color;
      req_read_address <= c.addr;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = render_command(c);
      pending_reports.push_back(typed ? typed_rpt : r);
      func_tally[c.func]++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      draw_report_type want;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, got read_data %0h pixels %0d",
                     $time, rsp_read_data, rsp_pixels_written);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data mismatch, expected %0h, got %0h",
                        $time, want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_pixels_written !== want.pixels) begin
               $display("%0t: pixels_written mismatch, expected %0d, got %0d",
                        $time, want.pixels, rsp_pixels_written);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      draw_report_type none;
      bit              no_idle;
      int              gap;
      none.read_data = '0;
      none.pixels    = '0;
      foreach (shadow_store[i]) shadow_store[i] = '0;
      foreach (func_tally[i]) func_tally[i] = 0;

      add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_READ, 255, 255, 255, 255, 255, 255, 15, 8191), 1, 0, 0);
      add_row(mk_cmd(FUNC_LINE, 0, 0, 0, 0, 0, 0, 15, 0), 1, 0, 1);
      add_row(mk_cmd(FUNC_LINE, 1, 0, 1, 0, 0, 0, 5, 0), 1, 0, 1);
      add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'hF5, 0);
      add_row(mk_cmd(FUNC_LINE, 127, 127, 127, 127, 0, 0, 10, 0), 1, 0, 1);
      add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8191), 1, 8'h0A, 0);
      // off-screen single pixels are clipped
      add_row(mk_cmd(FUNC_LINE, 128, 0, 128, 0, 0, 0, 15, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_LINE, 0, 128, 0, 128, 0, 0, 15, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_LINE, 255, 255, 0, 0, 0, 0, 3, 0), 0, 0, 0);
      add_row(mk_cmd(FUNC_LINE, 0, 127, 127, 0, 0, 0, 12, 0), 0, 0, 0);
      add_row(mk_cmd(FUNC_LINE, 10, 5, 200, 90, 0, 0, 9, 0), 0, 0, 0);
      add_row(mk_cmd(FUNC_LINE, 40, 120, 45, 2, 0, 0, 6, 0), 0, 0, 0);
      // zero width or height draws nothing
      add_row(mk_cmd(FUNC_OUTLINE, 0, 0, 0, 0, 0, 5, 15, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_OUTLINE, 3, 3, 0, 0, 5, 0, 15, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_OUTLINE, 120, 120, 0, 0, 20, 20, 4, 0), 0, 0, 0);
      // one-pixel outline plots the same pixel once from each of its sides
      add_row(mk_cmd(FUNC_OUTLINE, 5, 5, 0, 0, 1, 1, 8, 0), 1, 0, 4);
      add_row(mk_cmd(FUNC_FILL, 10, 10, 0, 0, 0, 7, 15, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_FILL, 0, 0, 0, 0, 255, 255, 7, 0), 1, 0, SCREEN_W * SCREEN_H);
      add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 4000), 1, 8'h77, 0);
      add_row(mk_cmd(FUNC_FILL, 255, 255, 0, 0, 255, 255, 2, 0), 1, 0, 0);
      add_row(mk_cmd(FUNC_SPARE_A, 255, 255, 255, 255, 255, 255, 15, 8191), 1, 0, 0);
      add_row(mk_cmd(FUNC_SPARE_B, 85, 170, 85, 170, 85, 170, 5, 2730), 1, 0, 0);
      add_row(mk_cmd(FUNC_SPARE_C, 170, 85, 170, 85, 170, 85, 10, 5461), 1, 0, 0);
      add_row(mk_cmd(FUNC_CLEAR, 255, 255, 255, 255, 255, 255, 15, 8191), 1, 0, 0);
      add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 4000), 1, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_cmd(directed_rows[i].cmd, $urandom_range(0, 10), directed_rows[i].typed,
                   directed_rows[i].report);

      no_idle = 1'b0;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         // every 40 commands, pick at random between an idle-gap phase and a back-to-back burst
         if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
         gap = no_idle ? 0 : $urandom_range(0, 10);
         drive_cmd(random_cmd(), gap, 1'b0, none);
      end
      start <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d clear, %0d line, %0d outline, %0d fill, %0d read,",
               directed_rows.size() + RANDOM_CMDS, func_tally[FUNC_CLEAR],
               func_tally[FUNC_LINE], func_tally[FUNC_OUTLINE], func_tally[FUNC_FILL],
               func_tally[FUNC_READ]);
      $display("and %0d unused codes, over %0d cycles with random idle gaps and bursts.",
               func_tally[FUNC_SPARE_A] + func_tally[FUNC_SPARE_B] + func_tally[FUNC_SPARE_C],
               cycle_count);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/nfb_pkg.sv
rtl/core/nfb_ram.sv
rtl/core/nibble_framebuffer_line_rect_drawer.sv
bench/tb_nibble_framebuffer_line_rect_drawer.sv
